FILE: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the min-heap queue
// Sizes, status and operation codes, sequencer states and the structs that
// travel between the sequencer, the heap memory and the compare unit.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	// heap size and derived widths
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KID_W    = IDX_W + 2;
	localparam int OUT_W    = ((2 * DATA_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_PAD  = OUT_W - 2 * DATA_W - CNT_W;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [KID_W-1:0]         kid_t;

	// operation carried with each input item
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_LD,
		S_DOWN,
		S_UP,
		S_UP_TOP,
		S_DONE
	} state_t;

	// heap memory write port
	typedef struct packed {
		logic  we;
		idx_t  addr;
		data_t data;
	} mem_wr_t;

	// compare unit operands: base against up to two candidates
	typedef struct packed {
		data_t base;
		data_t c0;
		logic  c0_ok;
		data_t c1;
		logic  c1_ok;
	} pick_req_t;

	// compare unit answer: which candidate replaces the base
	typedef struct packed {
		logic take0;
		logic take1;
	} pick_t;

	// one result item
	typedef struct packed {
		data_t   popped;
		status_t status;
		data_t   head;
		cnt_t    count;
	} result_t;

	// left child index of a heap slot
	function automatic kid_t left_of(idx_t p);
		return {1'b0, p, 1'b1};
	endfunction

endpackage

FILE: rtl/bmhq_store.sv
// ----------------------------------------------------------------------------
// bmhq_store: heap entry memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhq_store (
	input  logic              clk,
	input  bmhq_pkg::mem_wr_t wr,
	input  bmhq_pkg::idx_t    rd_a_addr,
	input  bmhq_pkg::idx_t    rd_b_addr,
	output bmhq_pkg::data_t   rd_a_q,
	output bmhq_pkg::data_t   rd_b_q
);

	bmhq_pkg::data_t mem_q [bmhq_pkg::CAPACITY];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_a_q <= mem_q[rd_a_addr];
		rd_b_q <= mem_q[rd_b_addr];
	end

endmodule

FILE: rtl/bmhq_pick.sv
// ----------------------------------------------------------------------------
// bmhq_pick: shared signed compare unit
// Decides whether the first or second candidate is strictly smaller than the
// running minimum; the first candidate wins ties against the second.
// ----------------------------------------------------------------------------
module bmhq_pick (
	input  bmhq_pkg::pick_req_t req,
	output bmhq_pkg::pick_t     res
);

	bmhq_pkg::data_t min_c0;
	logic            take0;

	// first candidate against base, then second against the running minimum
	always_comb begin
		take0     = req.c0_ok && (req.base > req.c0);
		min_c0    = take0 ? req.c0 : req.base;
		res.take0 = take0;
		res.take1 = req.c1_ok && (min_c0 > req.c1);
	end

endmodule

FILE: rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl: push and pop sequencer
// Holds the fill count and the moving entry, walks the heap one level per
// cycle through the compare unit and writes one entry per level.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  bmhq_pkg::op_t       mode,
	input  bmhq_pkg::data_t     value,
	input  logic                out_free,
	output logic                idle,
	output logic                done,
	output bmhq_pkg::result_t   res,
	output bmhq_pkg::mem_wr_t   wr,
	output bmhq_pkg::idx_t      rd_a_addr,
	output bmhq_pkg::idx_t      rd_b_addr,
	input  bmhq_pkg::data_t     rd_a,
	input  bmhq_pkg::data_t     rd_b,
	output bmhq_pkg::pick_req_t req,
	input  bmhq_pkg::pick_t     pick
);

	bmhq_pkg::state_t  state_q, state_d;
	bmhq_pkg::cnt_t    fill_q, fill_d;
	bmhq_pkg::idx_t    pos_q, pos_d;
	bmhq_pkg::idx_t    par_q, par_d;
	bmhq_pkg::data_t   val_q, val_d;
	bmhq_pkg::data_t   head_q;
	bmhq_pkg::data_t   popped_q, popped_d;
	bmhq_pkg::status_t status_q, status_d;

	bmhq_pkg::kid_t    kid_l, kid_r, nxt_l;
	bmhq_pkg::cnt_t    last;
	bmhq_pkg::idx_t    up_par;

	// state and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		par_q    <= par_d;
		val_q    <= val_d;
		popped_q <= popped_d;
		status_q <= status_d;
		if (wr.we && (wr.addr == '0)) begin
			head_q <= wr.data;
		end
	end

	// children of the current slot and the parent above the current parent
	assign kid_l  = bmhq_pkg::left_of(pos_q);
	assign kid_r  = kid_l + bmhq_pkg::KID_W'(1);
	assign last   = fill_q - bmhq_pkg::CNT_W'(1);
	assign up_par = (par_q - bmhq_pkg::IDX_W'(1)) >> 1;

	// result of the finished operation
	always_comb begin
		res.popped = popped_q;
		res.status = status_q;
		res.head   = (fill_q == '0) ? '0 : head_q;
		res.count  = fill_q;
	end

	// next state, memory accesses and compare operands
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		pos_d     = pos_q;
		par_d     = par_q;
		val_d     = val_q;
		popped_d  = popped_q;
		status_d  = status_q;
		wr        = '0;
		rd_a_addr = kid_l[bmhq_pkg::IDX_W-1:0];
		rd_b_addr = kid_r[bmhq_pkg::IDX_W-1:0];
		nxt_l     = '0;
		idle      = 1'b0;
		done      = 1'b0;
		req.base  = val_q;
		req.c0    = rd_a;
		req.c0_ok = kid_l < bmhq_pkg::KID_W'(fill_q);
		req.c1    = rd_b;
		req.c1_ok = kid_r < bmhq_pkg::KID_W'(fill_q);

		unique case (state_q)
			bmhq_pkg::S_IDLE: begin
				idle = 1'b1;
				if (take) begin
					popped_d = '0;
					status_d = bmhq_pkg::ST_OK;
					if (mode == bmhq_pkg::OP_PUSH) begin
						if (fill_q == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
							status_d = bmhq_pkg::ST_FULL;
							state_d  = bmhq_pkg::S_DONE;
						end else begin
							val_d  = value;
							pos_d  = fill_q[bmhq_pkg::IDX_W-1:0];
							fill_d = fill_q + bmhq_pkg::CNT_W'(1);
							if (fill_q == '0) begin
								wr      = '{we: 1'b1, addr: '0, data: value};
								state_d = bmhq_pkg::S_DONE;
							end else begin
								rd_a_addr = (fill_q[bmhq_pkg::IDX_W-1:0]
									- bmhq_pkg::IDX_W'(1)) >> 1;
								par_d     = rd_a_addr;
								state_d   = bmhq_pkg::S_UP;
							end
						end
					end else begin
						if (fill_q == '0) begin
							status_d = bmhq_pkg::ST_EMPTY;
							state_d  = bmhq_pkg::S_DONE;
						end else begin
							popped_d = head_q;
							fill_d   = last;
							if (last == '0) begin
								state_d = bmhq_pkg::S_DONE;
							end else begin
								rd_a_addr = last[bmhq_pkg::IDX_W-1:0];
								state_d   = bmhq_pkg::S_POP_LD;
							end
						end
					end
				end
			end

			// last entry arrives, hole moves to the root
			bmhq_pkg::S_POP_LD: begin
				val_d     = rd_a;
				pos_d     = '0;
				rd_a_addr = bmhq_pkg::IDX_W'(1);
				rd_b_addr = bmhq_pkg::IDX_W'(2);
				state_d   = bmhq_pkg::S_DOWN;
			end

			// sift down one level, reading the next children ahead
			bmhq_pkg::S_DOWN: begin
				if (pick.take1) begin
					wr        = '{we: 1'b1, addr: pos_q, data: rd_b};
					pos_d     = kid_r[bmhq_pkg::IDX_W-1:0];
					nxt_l     = bmhq_pkg::left_of(pos_d);
					rd_a_addr = nxt_l[bmhq_pkg::IDX_W-1:0];
					rd_b_addr = rd_a_addr + bmhq_pkg::IDX_W'(1);
				end else if (pick.take0) begin
					wr        = '{we: 1'b1, addr: pos_q, data: rd_a};
					pos_d     = kid_l[bmhq_pkg::IDX_W-1:0];
					nxt_l     = bmhq_pkg::left_of(pos_d);
					rd_a_addr = nxt_l[bmhq_pkg::IDX_W-1:0];
					rd_b_addr = rd_a_addr + bmhq_pkg::IDX_W'(1);
				end else begin
					wr      = '{we: 1'b1, addr: pos_q, data: val_q};
					state_d = bmhq_pkg::S_DONE;
				end
			end

			// sift up one level, reading the next parent ahead
			bmhq_pkg::S_UP: begin
				req.base  = rd_a;
				req.c0    = val_q;
				req.c0_ok = 1'b1;
				req.c1_ok = 1'b0;
				if (pick.take0) begin
					wr    = '{we: 1'b1, addr: pos_q, data: rd_a};
					pos_d = par_q;
					if (par_q == '0) begin
						state_d = bmhq_pkg::S_UP_TOP;
					end else begin
						rd_a_addr = up_par;
						par_d     = up_par;
					end
				end else begin
					wr      = '{we: 1'b1, addr: pos_q, data: val_q};
					state_d = bmhq_pkg::S_DONE;
				end
			end

			// moving entry lands on the root
			bmhq_pkg::S_UP_TOP: begin
				wr      = '{we: 1'b1, addr: '0, data: val_q};
				state_d = bmhq_pkg::S_DONE;
			end

			// hand the result to the output register
			bmhq_pkg::S_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = bmhq_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = bmhq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/binary_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit: bounded min-heap priority queue
// Push and pop of signed 32-bit entries with status, current minimum and
// entry count on every result item.
//
// channel   dir  tdata                                   tuser
// s_axis    in   value[31:0]                             mode[0]
// m_axis    out  popped[31:0] head[63:32] count[70:64]   status[1:0]
//
// A push rises in S_UP level by level, via S_UP_TOP at the root; on an empty or
// a full queue it goes straight to S_DONE. A pop passes S_POP_LD and sinks in
// S_DOWN level by level, or goes straight to S_DONE when it finds the queue
// empty or takes its only entry. Each level uses the single compare unit and
// one memory write. Reset empties the queue at once; no clearing pass runs over
// the memory. Input is taken only while the sequencer is idle; a finished item
// waits in the output register while the next input item is accepted.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [bmhq_pkg::DATA_W-1:0] s_axis_tdata,  // value
	input  logic [0:0]                 s_axis_tuser,  // mode
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [bmhq_pkg::OUT_W-1:0] m_axis_tdata,  // popped_value, head_value, entry_count
	output logic [1:0]                 m_axis_tuser   // status
);

	logic                take;
	logic                idle;
	logic                done;
	logic                out_free;
	bmhq_pkg::result_t   res;
	bmhq_pkg::mem_wr_t   wr;
	bmhq_pkg::idx_t      rd_a_addr, rd_b_addr;
	bmhq_pkg::data_t     rd_a, rd_b;
	bmhq_pkg::pick_req_t req;
	bmhq_pkg::pick_t     pick;
	logic                m_valid_q;
	bmhq_pkg::result_t   m_res_q;

	// input handshake
	assign s_axis_tready = idle;
	assign take          = s_axis_tvalid && idle;
	assign out_free      = !m_valid_q || m_axis_tready;

	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (bmhq_pkg::op_t'(s_axis_tuser[0])),
		.value     (bmhq_pkg::data_t'(s_axis_tdata)),
		.out_free  (out_free),
		.idle      (idle),
		.done      (done),
		.res       (res),
		.wr        (wr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.req       (req),
		.pick      (pick)
	);

	bmhq_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_q    (rd_a),
		.rd_b_q    (rd_b)
	);

	bmhq_pick u_pick (
		.req (req),
		.res (pick)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{bmhq_pkg::OUT_PAD{1'b0}}, m_res_q.count,
		m_res_q.head, m_res_q.popped};
	assign m_axis_tuser  = m_res_q.status;

	// count never exceeds the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_res_q.count <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)))
		else $error("entry count above capacity");

	// a dropped push only happens on a full heap
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_res_q.status == bmhq_pkg::ST_FULL))
		|-> (m_res_q.count == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)))
		else $error("full status with room left");

	// a failed pop leaves an empty heap and returns zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_res_q.status == bmhq_pkg::ST_EMPTY))
		|-> ((m_res_q.count == '0) && (m_res_q.popped == '0) && (m_res_q.head == '0)))
		else $error("empty status on a nonempty heap");

	// the sequencer is busy right after it takes an item
	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_axis_tready)
		else $error("ready right after accept");

endmodule

FILE: verif/binary_min_heap_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit_tb: self-checking bench of the min-heap queue
// A short table of pushes and pops covers the value extremes, ties, pops on
// an empty queue and pops with stray value bits. Then one sequence fills the
// queue past capacity and drains it past empty, and random phases follow with
// a changing mix of pushes and pops. Every result item is checked against a
// typed-in result or a bench heap model, with random idling on both streams.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit_tb;

	typedef bmhq_pkg::data_t   data_t;
	typedef bmhq_pkg::cnt_t    cnt_t;
	typedef bmhq_pkg::op_t     op_t;
	typedef bmhq_pkg::result_t result_t;

	localparam int CAPACITY = bmhq_pkg::CAPACITY;
	localparam int DATA_W   = bmhq_pkg::DATA_W;
	localparam int CNT_W    = bmhq_pkg::CNT_W;
	localparam int OUT_W    = bmhq_pkg::OUT_W;

	localparam op_t               OP_PUSH  = bmhq_pkg::OP_PUSH;
	localparam op_t               OP_POP   = bmhq_pkg::OP_POP;
	localparam bmhq_pkg::status_t ST_OK    = bmhq_pkg::ST_OK;
	localparam bmhq_pkg::status_t ST_EMPTY = bmhq_pkg::ST_EMPTY;
	localparam bmhq_pkg::status_t ST_FULL  = bmhq_pkg::ST_FULL;

	localparam int RAND_ITEMS  = 1150;
	localparam int CALM_ITEMS  = 150;
	localparam int PHASE_ITEMS = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 30;
	localparam int N_ROWS      = 23;

	// one table row: input item, whether the result is typed in, and that result
	typedef struct packed {
		op_t     op;
		data_t   value;
		logic    typed;
		result_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata;   // value
	logic [0:0]           s_axis_tuser;   // mode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // popped_value, head_value, entry_count
	logic [1:0]           m_axis_tuser;   // status

	// bench copy of the heap
	data_t       heap_img [CAPACITY];
	int          heap_fill;

	result_t     outcome_q [$];
	int          err_count;
	int          items_taken;
	bit          calm;
	bit          tx_jitter;
	bit          rx_jitter;
	bit          hold_req;

	// pushes and pops with hand-worked results where they are plain to see
	row_t dir_rows [N_ROWS] = '{
		{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 32'h0000_0000, 7'd0},
		{OP_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY, 32'h0000_0000, 7'd0},
		{OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    32'h7FFF_FFFF, 7'd1},
		{OP_PUSH, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    32'h8000_0000, 7'd2},
		{OP_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    32'h8000_0000, 7'd3},
		{OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    32'h8000_0000, 7'd4},
		{OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    32'h8000_0000, 7'd5},
		{OP_PUSH, 32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_PUSH, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    32'h8000_0000, 7'd7},
		{OP_POP,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK,    32'h8000_0000, 7'd6},
		{OP_POP,  32'h7FFF_FFFF, 1'b1, 32'h8000_0000, ST_OK,    32'hFFFF_FFFF, 7'd5},
		{OP_POP,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK,    32'hFFFF_FFFF, 7'd4},
		{OP_POP,  32'h8000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK,    32'h0000_0000, 7'd3},
		{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    32'h0000_0001, 7'd2},
		{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0001, ST_OK,    32'h7FFF_FFFF, 7'd1},
		{OP_POP,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK,    32'h0000_0000, 7'd0},
		{OP_POP,  32'h5555_5555, 1'b1, 32'h0000_0000, ST_EMPTY, 32'h0000_0000, 7'd0},
		{OP_PUSH, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_PUSH, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_PUSH, 32'h1234_5678, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_POP,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0},
		{OP_POP,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK,    32'h0000_0000, 7'd0}
	};

	binary_min_heap_queue_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("** binary_min_heap_queue_unit: FAILED **");
		$finish;
	end

	// apply one operation to the bench heap and return the result it gives;
	// a parent moves only when strictly greater, the left child wins ties
	function automatic result_t heap_op_outcome(op_t op, data_t v);
		result_t r;
		data_t   t;
		int      pos;
		int      up;
		int      kid;
		int      lo;
		bit      settled;
		r = '0;
		r.status = ST_OK;
		if (op == OP_PUSH) begin
			if (heap_fill >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				heap_img[heap_fill] = v;
				pos = heap_fill;
				heap_fill++;
				settled = 1'b0;
				while (pos > 0 && !settled) begin
					up = (pos - 1) / 2;
					if (heap_img[up] > heap_img[pos]) begin
						t = heap_img[up];
						heap_img[up] = heap_img[pos];
						heap_img[pos] = t;
						pos = up;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped = heap_img[0];
				heap_fill--;
				heap_img[0] = heap_img[heap_fill];
				pos = 0;
				settled = 1'b0;
				while (!settled) begin
					lo = pos;
					kid = 2 * pos + 1;
					if (kid < heap_fill && heap_img[lo] > heap_img[kid])
						lo = kid;
					if (kid + 1 < heap_fill && heap_img[lo] > heap_img[kid + 1])
						lo = kid + 1;
					if (lo == pos) begin
						settled = 1'b1;
					end else begin
						t = heap_img[lo];
						heap_img[lo] = heap_img[pos];
						heap_img[pos] = t;
						pos = lo;
					end
				end
			end
		end
		r.head  = (heap_fill > 0) ? heap_img[0] : '0;
		r.count = cnt_t'(heap_fill);
		return r;
	endfunction

	// random value: full range, a narrow band for ties, or an extreme
	function automatic data_t pick_value();
		data_t v;
		case ($urandom_range(3))
			1: v = data_t'(int'($urandom_range(16)) - 8);
			2: begin
				case ($urandom_range(3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7FFF_FFFF;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = data_t'($urandom);
		endcase
		return v;
	endfunction

	// offer one item, wait for it to be taken, then queue its result
	task automatic offer_item(op_t op, data_t v, logic typed, result_t want);
		result_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		items_taken++;
		r = heap_op_outcome(op, v);
		outcome_q = {outcome_q, (typed ? want : r)};
		if (!calm && tx_jitter && $urandom_range(5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// stop offering until every queued result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : rx_side
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !calm) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && rx_jitter && $urandom_range(7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		data_t   got_popped;
		data_t   got_head;
		cnt_t    got_count;
		if (m_axis_tvalid && m_axis_tready) begin
			got_popped = m_axis_tdata[DATA_W-1:0];
			got_head   = m_axis_tdata[2*DATA_W-1:DATA_W];
			got_count  = m_axis_tdata[2*DATA_W +: CNT_W];
			if (outcome_q.size() == 0) begin
				$error("result item with nothing outstanding");
				err_count++;
			end else begin
				want = outcome_q.pop_front();
				if (got_popped !== want.popped) begin
					$error("popped_value: expected %0d, got %0d", want.popped, got_popped);
					err_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					err_count++;
				end
				if (got_head !== want.head) begin
					$error("head_value: expected %0d, got %0d", want.head, got_head);
					err_count++;
				end
				if (got_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, got_count);
					err_count++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		result_t none;
		op_t     op;
		int      rand_start;
		int      pct;
		int      k;
		none        = '0;
		err_count   = 0;
		items_taken = 0;
		heap_fill   = 0;
		calm        = 1'b0;
		tx_jitter   = 1'b1;
		rx_jitter   = 1'b1;
		hold_req    = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_PUSH;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i])
			offer_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
		drain_results();
		rand_start = items_taken;

		// fill past capacity while the result side holds off, then drain past empty
		hold_req = 1'b1;
		for (k = 0; k < CAPACITY + 3; k++)
			offer_item(OP_PUSH, pick_value(), 1'b0, none);
		drain_results();
		for (k = 0; k < CAPACITY + 2; k++)
			offer_item(OP_POP, data_t'($urandom), 1'b0, none);
		drain_results();

		// random phases with a changing push/pop mix
		while (items_taken - rand_start < RAND_ITEMS) begin
			if (items_taken - rand_start >= RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			tx_jitter = ($urandom_range(3) != 0);
			rx_jitter = ($urandom_range(3) != 0);
			case ($urandom_range(3))
				0: pct = 15;
				1: pct = 50;
				2: pct = 85;
				default: pct = 97;
			endcase
			if (!calm && $urandom_range(4) == 0)
				drain_results();
			for (k = 0; k < PHASE_ITEMS; k++) begin
				op = ($urandom_range(99) < pct) ? OP_PUSH : OP_POP;
				offer_item(op, pick_value(), 1'b0, none);
			end
		end
		s_axis_tvalid <= 1'b0;

		// wait out every result, then a quiet tail
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("** binary_min_heap_queue_unit: PASSED **");
		end else begin
			$display("** binary_min_heap_queue_unit: FAILED **");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_store.sv
rtl/bmhq_pick.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue_unit.sv
verif/binary_min_heap_queue_unit_tb.sv
